>>> hw/rtl/wheel_pulse_speed_meter_top_assert.svh
// Assertion macros for the wheel pulse speed meter.
// Uses the clk and rst_n names of the including module.
`ifndef WHEEL_PULSE_SPEED_METER_TOP_ASSERT_SVH
`define WHEEL_PULSE_SPEED_METER_TOP_ASSERT_SVH
`ifndef SYNTH
`define WPSM_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("wpsm assertion failed");
`define WPSM_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpsm assertion failed");
`else
`define WPSM_CHECK(lbl, expr)
`define WPSM_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/wpsm_pkg.sv
// Shared types and constants of the wheel pulse speed meter.
// No dependencies.
package wpsm_pkg;

  localparam logic [1:0] OP_OVF  = 2'd0;
  localparam logic [1:0] OP_CAP  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_CLR  = 2'd3;

  localparam logic [2:0] REG_MIN_IV = 3'd0;
  localparam logic [2:0] REG_MAX_IV = 3'd1;
  localparam logic [2:0] REG_NUM    = 3'd2;
  localparam logic [2:0] REG_WGT    = 3'd3;
  localparam logic [2:0] REG_AF     = 3'd4;
  localparam logic [2:0] REG_STOP   = 3'd5;

  localparam logic [23:0] RST_MIN_IV = 24'd100;
  localparam logic [23:0] RST_MAX_IV = 24'd5000000;
  localparam logic [33:0] RST_NUM    = 34'd1440000000;
  localparam logic [8:0]  RST_WGT    = 9'd77;
  localparam logic [23:0] RST_AF     = 24'd2777778;
  localparam logic [15:0] RST_STOP   = 16'd200;

  localparam int DIV_DW = 40;
  localparam int DIV_VW = 24;

  typedef struct packed {
    logic busy;
    logic done;
  } dv_stat_t;

endpackage

>>> hw/rtl/wpsm_if.sv
// Handshake channels of the wheel pulse speed meter: input, result, config.
// No dependencies.
interface wpsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] capture_value;
  logic        hold;
  modport source (output valid, operation, capture_value, hold, input ready);
  modport sink (input valid, operation, capture_value, hold, output ready);
endinterface

interface wpsm_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        speed;
  logic signed [23:0] acceleration;
  logic [15:0]        peak_speed;
  logic [22:0]        peak_accel;
  logic [31:0]        pulse_count;
  logic               riding;
  logic               accepted;
  modport source (output valid, speed, acceleration, peak_speed, peak_accel, pulse_count,
                  riding, accepted, input ready);
  modport sink (input valid, speed, acceleration, peak_speed, peak_accel, pulse_count,
                riding, accepted, output ready);
endinterface

interface wpsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [33:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wpsm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wpsm_pkg.
module wpsm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wpsm_pkg::DIV_DW-1:0]  dividend,
  input  logic [wpsm_pkg::DIV_VW-1:0]  divisor,
  output logic [wpsm_pkg::DIV_DW-1:0]  quotient,
  output wpsm_pkg::dv_stat_t           stat
);
  import wpsm_pkg::*;

  localparam int CW = $clog2(DIV_DW + 1);

  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIV_VW:0]   rem_r;
  logic [DIV_DW-1:0] quo_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [DIV_VW:0]   sh;
  logic              ge;

  assign sh = {rem_r[DIV_VW-1:0], quo_r[DIV_DW-1]};
  assign ge = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? sh - {1'b0, dvs_r} : sh;
      quo_r <= {quo_r[DIV_DW-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

>>> hw/rtl/wpsm_median.sv
// Median of the interval ring, one candidate ranked per cycle.
// No package dependency.
module wpsm_median #(
  parameter int N = 5,
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] ring [N],
  output logic [W-1:0] median,
  output logic         done
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int RW = $clog2(N + 1);

  logic [IW-1:0] idx_r;
  logic          busy_r, done_r;
  logic [W-1:0]  med_r, cand;
  logic [N-1:0]  below;
  logic [RW-1:0] rank;

  assign cand = ring[idx_r];

  always_comb begin
    for (int j = 0; j < N; j++) begin
      below[j] = (ring[j] < cand) || ((ring[j] == cand) && (IW'(j) < idx_r));
    end
    rank = RW'($countones(below));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        if (idx_r == IW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && rank == RW'(N / 2)) begin
      med_r <= cand;
    end
  end

  assign median = med_r;
  assign done   = done_r;
endmodule

>>> hw/rtl/wheel_pulse_speed_meter_top.sv
// Wheel pulse speed meter: overflow, tick, clear and held items go via S_EXEC and S_DONE to
// the result register; an accepted capture uses the 40-step bit-serial divider for speed
// and, if the ring is full and its median > 100, for acceleration. One item is in work at a time;
// the next is taken while a finished result waits in the output register.
// Synchronous active-low reset (rst_n) restores register defaults and zeroes architectural state.
module wheel_pulse_speed_meter_top #(
  parameter int MEDIAN_SIZE = 5,
  parameter int TIMER_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  wpsm_in_if.sink    in_ch,
  wpsm_out_if.source out_ch,
  wpsm_cfg_if.sink   cfg_ch
);
  import wpsm_pkg::*;

  localparam int PW = (MEDIAN_SIZE > 1) ? $clog2(MEDIAN_SIZE) : 1;
  localparam logic [15:0] CAP_MASK =
    (TIMER_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << TIMER_WIDTH) - 1);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_OD    = 4'd2;
  localparam logic [3:0] S_SPAN  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_MED   = 4'd5;
  localparam logic [3:0] S_MEDW  = 4'd6;
  localparam logic [3:0] S_USED  = 4'd7;
  localparam logic [3:0] S_DIV1  = 4'd8;
  localparam logic [3:0] S_EWMA1 = 4'd9;
  localparam logic [3:0] S_EWMA2 = 4'd10;
  localparam logic [3:0] S_PEAK  = 4'd11;
  localparam logic [3:0] S_MUL   = 4'd12;
  localparam logic [3:0] S_DIV2  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // configuration registers
  logic [23:0] min_r, max_r, af_r;
  logic [33:0] num_r;
  logic [8:0]  wgt_r;
  logic [15:0] stop_r;

  // measurement state
  logic [3:0]         state_r;
  logic [1:0]         op_r;
  logic [15:0]        cap_r, last_cap_r, prev_cap_r;
  logic               hold_r;
  logic [31:0]        oc_r, oal_r, od_r;
  logic               od_big_r;
  logic signed [65:0] span_r;
  logic [23:0]        ring_r [MEDIAN_SIZE];
  logic [PW-1:0]      pos_r;
  logic               full_r;
  logic [23:0]        interval_r, used_r;
  logic [31:0]        pulses_r;
  logic [15:0]        smooth_r, prev_r, maxs_r, raw_r, dmag_r;
  logic               dneg_r;
  logic [24:0]        p1_r, p2_r;
  logic signed [23:0] accel_r;
  logic [22:0]        maxa_r;
  logic               active_r, acc_r;
  logic [15:0]        idle_r;

  // result register
  logic               ov_r;
  logic [15:0]        o_speed_r, o_peak_r;
  logic signed [23:0] o_accel_r;
  logic [22:0]        o_peaka_r;
  logic [31:0]        o_pulses_r;
  logic               o_riding_r, o_acc_r;

  // shared units
  logic              div_start, med_start, med_done;
  logic [DIV_DW-1:0] div_dividend, div_q;
  dv_stat_t          dv_stat;
  logic [23:0]       med_val;

  logic [15:0]        idle_inc;
  logic [8:0]         w_eff;
  logic [25:0]        ewma_sum;
  logic [39:0]        prod;
  logic signed [65:0] span_calc;
  logic               reject;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign idle_inc  = 16'(idle_r + 16'd1);
  assign w_eff     = (wgt_r > 9'd256) ? 9'd256 : wgt_r;
  assign ewma_sum  = 26'(p1_r) + 26'(p2_r) + 26'd128;
  assign prod      = 40'(dmag_r) * 40'(af_r);
  assign span_calc = $signed({2'b00, 64'(od_r) << TIMER_WIDTH})
                   + $signed({50'd0, prev_cap_r ^ prev_cap_r ^ cap_r})
                   - $signed({50'd0, prev_cap_r});
  assign reject    = od_big_r || span_r < 0 || span_r < $signed({42'd0, min_r})
                  || span_r > $signed({42'd0, max_r});

  assign div_start    = (state_r == S_USED && used_r != '0) || state_r == S_MUL;
  assign div_dividend = (state_r == S_MUL) ? prod : {6'd0, num_r};
  assign med_start    = (state_r == S_MED) && full_r;

  wpsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (used_r),
    .quotient (div_q),
    .stat     (dv_stat)
  );

  wpsm_median #(.N(MEDIAN_SIZE), .W(24)) u_med (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (med_start),
    .ring   (ring_r),
    .median (med_val),
    .done   (med_done)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= RST_MIN_IV;
      max_r  <= RST_MAX_IV;
      num_r  <= RST_NUM;
      wgt_r  <= RST_WGT;
      af_r   <= RST_AF;
      stop_r <= RST_STOP;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIN_IV: min_r  <= cfg_ch.data[23:0];
        REG_MAX_IV: max_r  <= cfg_ch.data[23:0];
        REG_NUM:    num_r  <= cfg_ch.data;
        REG_WGT:    wgt_r  <= cfg_ch.data[8:0];
        REG_AF:     af_r   <= cfg_ch.data[23:0];
        REG_STOP:   stop_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // ring storage, payload only; entries are read only once all have been rewritten
  always_ff @(posedge clk) begin
    if (state_r == S_CHK && !reject) begin
      ring_r[pos_r] <= span_r[23:0];
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r   <= in_ch.operation;
        cap_r  <= in_ch.capture_value & CAP_MASK;
        hold_r <= in_ch.hold;
      end
      S_OD: begin
        od_r       <= oc_r - oal_r;
        od_big_r   <= (oc_r - oal_r) > 32'h0100_0000;
        prev_cap_r <= last_cap_r;
      end
      S_SPAN:  span_r <= span_calc;
      S_CHK:   interval_r <= span_r[23:0];
      S_MED:   if (!full_r) used_r <= interval_r;
      S_MEDW:  if (med_done) used_r <= med_val;
      S_DIV1:  raw_r <= (div_q > 40'd65535) ? 16'hFFFF : div_q[15:0];
      S_EWMA1: begin
        p1_r <= 25'(w_eff) * 25'(raw_r);
        p2_r <= 25'(9'd256 - w_eff) * 25'(smooth_r);
      end
      S_PEAK: begin
        dneg_r <= smooth_r < prev_r;
        dmag_r <= (smooth_r < prev_r) ? prev_r - smooth_r : smooth_r - prev_r;
      end
      default: ;
    endcase
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      oc_r       <= '0;
      oal_r      <= '0;
      last_cap_r <= '0;
      pos_r      <= '0;
      full_r     <= 1'b0;
      pulses_r   <= '0;
      smooth_r   <= '0;
      prev_r     <= '0;
      maxs_r     <= '0;
      accel_r    <= '0;
      maxa_r     <= '0;
      active_r   <= 1'b0;
      idle_r     <= '0;
      acc_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      if (out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          acc_r <= 1'b0;
          if (in_ch.valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          case (op_r)
            OP_OVF: oc_r <= oc_r + 32'd1;
            OP_CAP: if (!hold_r) state_r <= S_OD;
            OP_TICK: begin
              if (!hold_r && active_r) begin
                if (idle_inc >= stop_r) begin
                  // timeout: stop riding and forget the ring
                  active_r <= 1'b0;
                  smooth_r <= '0;
                  accel_r  <= '0;
                  prev_r   <= '0;
                  idle_r   <= '0;
                  pos_r    <= '0;
                  full_r   <= 1'b0;
                end else begin
                  idle_r <= idle_inc;
                end
              end
            end
            default: begin
              pulses_r <= '0;
              smooth_r <= '0;
              prev_r   <= '0;
              maxs_r   <= '0;
              accel_r  <= '0;
              maxa_r   <= '0;
              oc_r     <= '0;
              oal_r    <= '0;
              pos_r    <= '0;
              full_r   <= 1'b0;
            end
          endcase
        end
        S_OD: begin
          last_cap_r <= cap_r;
          oal_r      <= oc_r;
          state_r    <= S_SPAN;
        end
        S_SPAN: state_r <= S_CHK;
        S_CHK: begin
          if (reject) begin
            state_r <= S_DONE;
          end else begin
            if (pos_r == PW'(MEDIAN_SIZE - 1)) begin
              pos_r  <= '0;
              full_r <= 1'b1;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
            pulses_r <= pulses_r + 32'd1;
            active_r <= 1'b1;
            idle_r   <= '0;
            acc_r    <= 1'b1;
            state_r  <= S_MED;
          end
        end
        S_MED:  state_r <= full_r ? S_MEDW : S_USED;
        S_MEDW: if (med_done) state_r <= S_USED;
        S_USED: begin
          if (used_r == '0) begin
            smooth_r <= '0;
            prev_r   <= '0;
            accel_r  <= '0;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (dv_stat.done) begin
            if (pulses_r <= 32'd1 || !full_r) begin
              smooth_r <= (div_q > 40'd65535) ? 16'hFFFF : div_q[15:0];
              state_r  <= S_PEAK;
            end else begin
              state_r <= S_EWMA1;
            end
          end
        end
        S_EWMA1: state_r <= S_EWMA2;
        S_EWMA2: begin
          smooth_r <= ewma_sum[23:8];
          state_r  <= S_PEAK;
        end
        S_PEAK: begin
          if (smooth_r > maxs_r) maxs_r <= smooth_r;
          if (pulses_r > 32'd1 && full_r && used_r > 24'd100) begin
            state_r <= S_MUL;
          end else begin
            accel_r <= '0;
            prev_r  <= smooth_r;
            state_r <= S_DONE;
          end
        end
        S_MUL: state_r <= S_DIV2;
        S_DIV2: begin
          if (dv_stat.done) begin
            if (dneg_r) begin
              accel_r <= (div_q > 40'd8388608) ? -24'sd8388608 : -$signed(div_q[23:0]);
            end else begin
              accel_r <= (div_q > 40'd8388607) ? 24'sd8388607 : $signed(div_q[23:0]);
              if (div_q > 40'(maxa_r)) begin
                maxa_r <= (div_q > 40'd8388607) ? 23'h7FFFFF : div_q[22:0];
              end
            end
            prev_r  <= smooth_r;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_r || out_ch.ready) begin
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded as the item finishes
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!ov_r || out_ch.ready)) begin
      o_speed_r  <= smooth_r;
      o_accel_r  <= accel_r;
      o_peak_r   <= maxs_r;
      o_peaka_r  <= maxa_r;
      o_pulses_r <= pulses_r;
      o_riding_r <= active_r;
      o_acc_r    <= acc_r;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.speed        = o_speed_r;
  assign out_ch.acceleration = o_accel_r;
  assign out_ch.peak_speed   = o_peak_r;
  assign out_ch.peak_accel   = o_peaka_r;
  assign out_ch.pulse_count  = o_pulses_r;
  assign out_ch.riding       = o_riding_r;
  assign out_ch.accepted     = o_acc_r;

`include "wheel_pulse_speed_meter_top_assert.svh"

  `WPSM_CHECK_NEXT(a_accept_exec, in_ch.valid && in_ch.ready, state_r == S_EXEC)
  `WPSM_CHECK(a_div_idle_start, !div_start || !dv_stat.busy)
  `WPSM_CHECK(a_peak_covers, !out_ch.valid || out_ch.peak_speed >= out_ch.speed)
  `WPSM_CHECK(a_stopped_still, !out_ch.valid || out_ch.riding || out_ch.speed == 16'd0)
endmodule

>>> verif/wpsm_checker.sv
// Checker of the wheel pulse speed meter: watches the input, result and config channels,
// predicts every result and compares it field by field. Depends on wpsm_pkg and wpsm_if.
module wpsm_checker #(
  parameter int MEDIAN_SIZE = 5,
  parameter int TIMER_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  wpsm_in_if   in_ch,
  wpsm_out_if  out_ch,
  wpsm_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);
  import wpsm_pkg::*;

  typedef struct {
    logic [15:0]        speed;
    logic signed [23:0] accel;
    logic [15:0]        peak_speed;
    logic [22:0]        peak_accel;
    logic [31:0]        pulses;
    logic               riding;
    logic               accepted;
  } meter_res_t;

  meter_res_t result_q[$];

  // configuration copy
  logic [23:0] min_iv, max_iv, acc_fac;
  logic [33:0] numer;
  logic [8:0]  weight;
  logic [15:0] stop_lim;

  // measurement state
  logic [31:0] ovf_cnt, ovf_last, pulse_cnt;
  logic [15:0] last_cap, cur_speed, prev_speed, top_speed, idle_cnt;
  logic [23:0] ring [MEDIAN_SIZE];
  int          ring_idx;
  logic        ring_done, moving;
  logic signed [23:0] cur_accel;
  logic [22:0] top_accel;

  task automatic empty_ring();
    for (int i = 0; i < MEDIAN_SIZE; i++) ring[i] = '0;
    ring_idx  = 0;
    ring_done = 1'b0;
  endtask

  function automatic logic [23:0] ring_mid();
    logic [23:0] t [MEDIAN_SIZE];
    logic [23:0] x;
    for (int i = 0; i < MEDIAN_SIZE; i++) t[i] = ring[i];
    for (int i = 0; i < MEDIAN_SIZE; i++)
      for (int j = 0; j < MEDIAN_SIZE - 1 - i; j++)
        if (t[j] > t[j+1]) begin
          x = t[j]; t[j] = t[j+1]; t[j+1] = x;
        end
    return t[MEDIAN_SIZE/2];
  endfunction

  task automatic take_pulse(input logic [15:0] cap, output logic ok);
    logic [15:0] prev;
    logic [31:0] od;
    longint      span;
    longint unsigned used, raw, w, mag;
    longint      d;
    prev     = last_cap;
    od       = ovf_cnt - ovf_last;
    last_cap = cap;
    ovf_last = ovf_cnt;
    ok       = 1'b0;
    if (od > 32'h0100_0000) return;
    span = (longint'(od) << TIMER_WIDTH) + longint'(cap) - longint'(prev);
    if (span < 0 || span < longint'(min_iv) || span > longint'(max_iv)) return;
    ok = 1'b1;
    ring[ring_idx] = span[23:0];
    ring_idx++;
    if (ring_idx >= MEDIAN_SIZE) begin
      ring_idx  = 0;
      ring_done = 1'b1;
    end
    used = ring_done ? ring_mid() : span;
    pulse_cnt++;
    moving   = 1'b1;
    idle_cnt = '0;
    if (used == 0) begin
      cur_speed  = '0;
      prev_speed = '0;
      cur_accel  = '0;
      return;
    end
    raw = longint'(numer) / used;
    if (raw > 65535) raw = 65535;
    if (pulse_cnt <= 1 || !ring_done) cur_speed = raw[15:0];
    else begin
      w = (weight > 256) ? 256 : weight;
      cur_speed = 16'((w * raw + (256 - w) * cur_speed + 128) >> 8);
    end
    if (cur_speed > top_speed) top_speed = cur_speed;
    if (pulse_cnt > 1 && ring_done && used > 100) begin
      d   = longint'(cur_speed) - longint'(prev_speed);
      mag = longint'(d < 0 ? -d : d) * acc_fac / used;
      if (d < 0) cur_accel = (mag > 8388608) ? -24'sd8388608 : -24'(mag);
      else       cur_accel = (mag > 8388607) ? 24'sd8388607 : 24'(mag);
      if (cur_accel > 0 && cur_accel[22:0] > top_accel) top_accel = cur_accel[22:0];
    end else cur_accel = '0;
    prev_speed = cur_speed;
  endtask

  task automatic wipe_data();
    pulse_cnt  = '0;
    cur_speed  = '0;
    prev_speed = '0;
    top_speed  = '0;
    cur_accel  = '0;
    top_accel  = '0;
    ovf_cnt    = '0;
    ovf_last   = '0;
    empty_ring();
  endtask

  task automatic meter_step(input logic [1:0] op, input logic [15:0] cap, input logic hold);
    meter_res_t r;
    logic ok;
    ok = 1'b0;
    case (op)
      OP_OVF: ovf_cnt++;
      OP_CAP: if (!hold) take_pulse(cap, ok);
      OP_TICK: begin
        if (!hold && moving) begin
          idle_cnt++;
          if (idle_cnt >= stop_lim) begin
            moving     = 1'b0;
            cur_speed  = '0;
            cur_accel  = '0;
            prev_speed = '0;
            idle_cnt   = '0;
            empty_ring();
          end
        end
      end
      default: wipe_data();
    endcase
    r.speed      = cur_speed;
    r.accel      = cur_accel;
    r.peak_speed = top_speed;
    r.peak_accel = top_accel;
    r.pulses     = pulse_cnt;
    r.riding     = moving;
    r.accepted   = ok;
    result_q.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = result_q.size();

  always @(posedge clk) begin
    meter_res_t e;
    if (!rst_n) begin
      min_iv   = RST_MIN_IV;
      max_iv   = RST_MAX_IV;
      numer    = RST_NUM;
      weight   = RST_WGT;
      acc_fac  = RST_AF;
      stop_lim = RST_STOP;
      wipe_data();
      last_cap = '0;
      moving   = 1'b0;
      idle_cnt = '0;
      result_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MIN_IV: min_iv   = cfg_ch.data[23:0];
          REG_MAX_IV: max_iv   = cfg_ch.data[23:0];
          REG_NUM:    numer    = cfg_ch.data;
          REG_WGT:    weight   = cfg_ch.data[8:0];
          REG_AF:     acc_fac  = cfg_ch.data[23:0];
          REG_STOP:   stop_lim = cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) report("unexpected item", 0, 0);
        else begin
          e = result_q.pop_front();
          if (out_ch.speed !== e.speed) report("speed", out_ch.speed, e.speed);
          if (out_ch.acceleration !== e.accel) report("acceleration", out_ch.acceleration, e.accel);
          if (out_ch.peak_speed !== e.peak_speed)
            report("peak_speed", out_ch.peak_speed, e.peak_speed);
          if (out_ch.peak_accel !== e.peak_accel)
            report("peak_accel", out_ch.peak_accel, e.peak_accel);
          if (out_ch.pulse_count !== e.pulses) report("pulse_count", out_ch.pulse_count, e.pulses);
          if (out_ch.riding !== e.riding) report("riding", out_ch.riding, e.riding);
          if (out_ch.accepted !== e.accepted) report("accepted", out_ch.accepted, e.accepted);
        end
      end
      if (in_ch.valid && in_ch.ready)
        meter_step(in_ch.operation, in_ch.capture_value, in_ch.hold);
    end
  end
endmodule

>>> verif/wheel_pulse_speed_meter_top_test.sv
// Testbench top of the wheel pulse speed meter: clock, reset, stimulus and verdict.
// Depends on wpsm_pkg, wpsm_if, wpsm_checker and the block itself.
module wheel_pulse_speed_meter_top_test;
  import wpsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, pending, cycles;

  wpsm_in_if  in_ch();
  wpsm_out_if out_ch();
  wpsm_cfg_if cfg_ch();

  wheel_pulse_speed_meter_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  wpsm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  // sender/receiver gap ceilings: 0 gives a stretch with no idling
  int tx_max = 9;
  int rx_max = 9;
  // receiver long hold-off request, served in the receiver process
  bit long_req = 0;
  bit long_done = 0;
  int long_left = 0;
  int rx_wait = 0;
  // timer value of the last capture the block took (hold 0)
  logic [15:0] last_cap = '0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_OVF;
    in_ch.capture_value = '0;
    in_ch.hold = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MIN_IV;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall per item, plus one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (long_req && !long_done) begin
      long_done = 1;
      long_left = 600;
      out_ch.ready <= 1'b0;
    end else if (long_left > 0) begin
      long_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_wait = $urandom_range(0, rx_max);
      out_ch.ready <= (rx_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One item; valid stays high into the next item when there is no gap.
  task automatic send(input logic [1:0] op, input logic [15:0] cap, input logic hold);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.capture_value <= cap;
    in_ch.hold <= hold;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_CAP && !hold) last_cap = cap;
  endtask

  // Well-formed wheel pulse: the overflows that the span crosses, then the capture.
  task automatic pulse(input int span);
    longint nxt;
    nxt = longint'(last_cap) + span;
    for (longint k = 0; k < (nxt >> 16); k++)
      send(OP_OVF, 16'($urandom), $urandom_range(0, 7) == 0);
    send(OP_CAP, nxt[15:0], 1'b0);
  endtask

  // Let the block drain, then idle out its latency before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [33:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [23:0] mn, input logic [23:0] mx, input logic [33:0] num,
                          input logic [8:0] w, input logic [23:0] af, input logic [15:0] st);
    write_reg(REG_MIN_IV, mn);
    write_reg(REG_MAX_IV, mx);
    write_reg(REG_NUM, num);
    write_reg(REG_WGT, w);
    write_reg(REG_AF, af);
    write_reg(REG_STOP, st);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly pulses with random spacing; some tick bursts, clears and plain noise.
  task automatic random_items(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel % 37 == 0) begin
        tx_max = (tx_max == 0) ? 9 : 0;
        rx_max = (rx_max == 0) ? 9 : 0;
      end
      if (sel < 45) pulse($urandom_range(100, 30000));
      else if (sel < 58) pulse($urandom_range(30000, 250000));
      else if (sel < 63) pulse($urandom_range(0, 200));
      else if (sel < 64) pulse($urandom_range(250000, 1500000));
      else if (sel < 78)
        repeat ($urandom_range(1, 6)) send(OP_TICK, 16'($urandom), $urandom_range(0, 5) == 0);
      else if (sel < 81) send(OP_CLR, 16'($urandom), 1'($urandom_range(0, 1)));
      else send(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values
    send(OP_CLR, 16'h0000, 1'b0);
    send(OP_OVF, 16'hFFFF, 1'b1);     // overflow still counted under hold
    send(OP_CAP, 16'd1000, 1'b0);
    send(OP_CAP, 16'd1050, 1'b0);     // too short, rejected
    pulse(1000); pulse(1200); pulse(900); pulse(1100); pulse(60000);
    send(OP_CAP, 16'hFFFF, 1'b1);     // capture under hold does nothing
    send(OP_TICK, 16'h0000, 1'b1);    // held tick does nothing
    send(OP_TICK, 16'hFFFF, 1'b0);
    send(OP_CLR, 16'hFFFF, 1'b1);     // clear is performed under hold
    send(OP_CAP, 16'h0000, 1'b0);
    send(OP_CAP, 16'hFFFF, 1'b0);
    settle();

    // Extremes: zero interval allowed, widest limits, stop on first tick
    set_regs(24'd0, 24'hFFFFFF, 34'h3FFFFFFFF, 9'd256, 24'hFFFFFF, 16'd1);
    send(OP_CAP, last_cap, 1'b0);     // zero interval
    pulse(500); pulse(300); pulse(800); pulse(150); pulse(0);
    send(OP_TICK, 16'h1234, 1'b0);    // stops riding at once
    long_req = 1;                     // receiver holds off while items keep coming
    random_items(70);
    settle();

    // Nothing fits: everything rejected
    set_regs(24'hFFFFFF, 24'd0, 34'd1, 9'd1, 24'd1, 16'd65535);
    random_items(15);
    settle();

    // Smallest weight/numerator/factor, no timeout
    set_regs(24'd50, 24'd2000000, 34'd1, 9'd1, 24'd1, 16'd65535);
    random_items(30);
    settle();

    // Random settings
    for (int p = 0; p < 3; p++) begin
      set_regs(24'($urandom_range(0, 400)), 24'($urandom_range(100000, 16777215)),
               {2'($urandom_range(0, 3)), 32'($urandom)} | 34'd1,
               9'($urandom_range(1, 256)), 24'($urandom_range(1, 16777215)),
               16'($urandom_range(1, 12)));
      random_items(50);
      settle();
    end

    // Back to reset values
    set_regs(RST_MIN_IV, RST_MAX_IV, RST_NUM, RST_WGT, RST_AF, RST_STOP);
    random_items(20);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
